// ===== hw/rtl/mgram_pkg.sv =====
`default_nettype none

package mgram_pkg;

  localparam int unsigned NUM_ANT     = 4;
  localparam int unsigned NUM_ENTRIES = 10;
  localparam int unsigned ENT_W       = 4;
  localparam int unsigned NUM_STEPS   = 5;
  localparam int unsigned STEP_W      = 3;
  localparam int unsigned ACC_W       = 36;
  localparam int unsigned NV_W        = 32;

  localparam logic [ENT_W-1:0]  LAST_ENTRY = ENT_W'(NUM_ENTRIES - 1);
  localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(NUM_STEPS - 1);

  // Queue status seen by the back end
  typedef struct packed {
    logic valid;
    logic last;
  } qctl_t;

  // Row index of each entry, in emission order
  function automatic logic [1:0] entry_row(input logic [ENT_W-1:0] e);
    logic [1:0] r;
    unique case (e)
      4'd0:                      r = 2'd0;
      4'd1, 4'd2:                r = 2'd1;
      4'd3, 4'd4, 4'd5:          r = 2'd2;
      4'd6, 4'd7, 4'd8, 4'd9:    r = 2'd3;
      default:                   r = 2'd0;
    endcase
    return r;
  endfunction

  // Column index of each entry, in emission order
  function automatic logic [1:0] entry_col(input logic [ENT_W-1:0] e);
    logic [1:0] c;
    unique case (e)
      4'd0, 4'd2, 4'd5, 4'd9:    c = 2'd0;
      4'd1, 4'd4, 4'd8:          c = 2'd1;
      4'd3, 4'd7:                c = 2'd2;
      4'd6:                      c = 2'd3;
      default:                   c = 2'd0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mgram_front.sv =====
`default_nettype none

module mgram_front #(
  parameter int unsigned DATA_W = 128
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DATA_W-1:0] row_i,
  input  wire logic              last_row_i,
  output logic                   busy_o,
  output mgram_pkg::qctl_t       qctl_o,
  output logic [DATA_W-1:0]      row_o,
  input  wire logic              pop_i
);
  import mgram_pkg::*;

  localparam int unsigned ENTRY_W = DATA_W + 1;

  logic [ENTRY_W-1:0] mem_q [2];
  logic               wr_ptr_q, wr_ptr_d;
  logic               rd_ptr_q, rd_ptr_d;
  logic [1:0]         count_q, count_d;
  logic               push;
  logic               full;

  assign full   = (count_q == 2'd2);
  assign busy_o = full;
  assign push   = start_i && !full;

  always_comb begin
    wr_ptr_d = push  ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    unique case ({push, pop_i})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Tag each row with its last-row mark as it enters the queue
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= {last_row_i, row_i};
    end
  end

  assign qctl_o.valid = (count_q != 2'd0);
  assign qctl_o.last  = mem_q[rd_ptr_q][ENTRY_W-1];
  assign row_o        = mem_q[rd_ptr_q][DATA_W-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/mgram_back.sv =====
`default_nettype none

module mgram_back #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire mgram_pkg::qctl_t              qctl_i,
  input  wire logic [8*SAMPLE_WIDTH-1:0]     row_i,
  output logic                               pop_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [mgram_pkg::NV_W-1:0]    cfg_wdata_i,
  output logic                               result_valid_o,
  output logic [1:0]                         gram_row_o,
  output logic [1:0]                         gram_col_o,
  output logic signed [mgram_pkg::ACC_W-1:0] gram_re_o,
  output logic signed [mgram_pkg::ACC_W-1:0] gram_im_o,
  output logic                               last_entry_o
);
  import mgram_pkg::*;

  localparam int unsigned SW     = SAMPLE_WIDTH;
  localparam int unsigned PROD_W = 2 * SAMPLE_WIDTH;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MUL   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [ENT_W-1:0]  emit_cnt_q, emit_cnt_d;
  logic [8*SW-1:0]   row_q;
  logic              last_q;
  logic [NV_W-1:0]   noise_var_q;
  logic              clr;

  logic signed [SW-1:0] re_a [NUM_ANT];
  logic signed [SW-1:0] im_a [NUM_ANT];

  // Product stage, two entries per step
  logic signed [PROD_W-1:0] p_rr_q [2], p_ii_q [2], p_ri_q [2], p_ir_q [2];
  logic signed [PROD_W-1:0] p_rr_d [2], p_ii_d [2], p_ri_d [2], p_ir_d [2];
  logic                     p_valid_q;
  logic [STEP_W-1:0]        p_step_q;

  logic signed [ACC_W-1:0] sum_re [2];
  logic signed [ACC_W-1:0] sum_im [2];
  logic signed [ACC_W-1:0] acc_re_q [NUM_ENTRIES], acc_re_d [NUM_ENTRIES];
  logic signed [ACC_W-1:0] acc_im_q [NUM_ENTRIES], acc_im_d [NUM_ENTRIES];

  logic                    res_valid_q;
  logic [1:0]              res_row_q, res_col_q;
  logic signed [ACC_W-1:0] res_re_q, res_im_q;
  logic                    res_last_q;
  logic [1:0]              emit_row, emit_col;

  // Sequencer
  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    emit_cnt_d = emit_cnt_q;
    pop_o      = 1'b0;
    clr        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (qctl_i.valid) begin
          pop_o   = 1'b1;
          step_d  = '0;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (step_q == LAST_STEP) begin
          step_d = '0;
          priority if (last_q) begin
            state_d = ST_DRAIN;
          end else if (qctl_i.valid) begin
            pop_o = 1'b1;
          end else begin
            state_d = ST_IDLE;
          end
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      ST_DRAIN: begin
        emit_cnt_d = '0;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_cnt_q == LAST_ENTRY) begin
          clr     = 1'b1;
          state_d = ST_IDLE;
        end else begin
          emit_cnt_d = emit_cnt_q + ENT_W'(1);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      emit_cnt_q  <= '0;
      last_q      <= 1'b0;
      p_valid_q   <= 1'b0;
      p_step_q    <= '0;
      noise_var_q <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      emit_cnt_q  <= emit_cnt_d;
      p_valid_q   <= (state_q == ST_MUL);
      p_step_q    <= step_q;
      res_valid_q <= (state_q == ST_EMIT);
      if (pop_o) begin
        last_q <= qctl_i.last;
      end
      if (cfg_we_i) begin
        noise_var_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      row_q <= row_i;
    end
  end

  // Unpack the held row
  always_comb begin
    for (int n = 0; n < NUM_ANT; n++) begin
      re_a[n] = row_q[(2*n)*SW +: SW];
      im_a[n] = row_q[(2*n+1)*SW +: SW];
    end
  end

  // Entry 2*step + lane goes through lane 'lane'
  always_comb begin
    logic [ENT_W-1:0] e;
    logic [1:0]       ri, cj;
    for (int l = 0; l < 2; l++) begin
      e         = {step_q, l[0]};
      ri        = entry_row(e);
      cj        = entry_col(e);
      p_rr_d[l] = re_a[ri] * re_a[cj];
      p_ii_d[l] = im_a[ri] * im_a[cj];
      p_ri_d[l] = re_a[ri] * im_a[cj];
      p_ir_d[l] = im_a[ri] * re_a[cj];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 2; l++) begin
      p_rr_q[l] <= p_rr_d[l];
      p_ii_q[l] <= p_ii_d[l];
      p_ri_q[l] <= p_ri_d[l];
      p_ir_q[l] <= p_ir_d[l];
    end
  end

  // Products fold into the accumulator width modulo 2^ACC_W
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      sum_re[l] = ACC_W'(p_rr_q[l]) + ACC_W'(p_ii_q[l]);
      sum_im[l] = ACC_W'(p_ri_q[l]) - ACC_W'(p_ir_q[l]);
    end
  end

  always_comb begin
    for (int e = 0; e < NUM_ENTRIES; e++) begin
      acc_re_d[e] = acc_re_q[e];
      acc_im_d[e] = acc_im_q[e];
      if (clr) begin
        acc_re_d[e] = '0;
        acc_im_d[e] = '0;
      end else if (p_valid_q && (p_step_q == STEP_W'(e >> 1))) begin
        acc_re_d[e] = acc_re_q[e] + sum_re[e & 1];
        if (entry_row(ENT_W'(e)) != entry_col(ENT_W'(e))) begin
          acc_im_d[e] = acc_im_q[e] + sum_im[e & 1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int e = 0; e < NUM_ENTRIES; e++) begin
        acc_re_q[e] <= '0;
        acc_im_q[e] <= '0;
      end
    end else begin
      for (int e = 0; e < NUM_ENTRIES; e++) begin
        acc_re_q[e] <= acc_re_d[e];
        acc_im_q[e] <= acc_im_d[e];
      end
    end
  end

  // Result register: one entry per cycle while emitting
  assign emit_row = entry_row(emit_cnt_q);
  assign emit_col = entry_col(emit_cnt_q);

  always_ff @(posedge clk_i) begin
    res_row_q  <= emit_row;
    res_col_q  <= emit_col;
    res_last_q <= (emit_cnt_q == LAST_ENTRY);
    if (emit_row == emit_col) begin
      res_re_q <= acc_re_q[emit_cnt_q] + ACC_W'(noise_var_q);
      res_im_q <= '0;
    end else begin
      res_re_q <= acc_re_q[emit_cnt_q];
      res_im_q <= acc_im_q[emit_cnt_q];
    end
  end

  assign result_valid_o = res_valid_q;
  assign gram_row_o     = res_row_q;
  assign gram_col_o     = res_col_q;
  assign gram_re_o      = res_re_q;
  assign gram_im_o      = res_im_q;
  assign last_entry_o   = res_last_q;

endmodule

`default_nettype wire

// ===== hw/rtl/mimo_gram_matrix_4x4.sv =====
// Gram matrix H^H*H + noise_variance*I of a 4x4 complex channel, one row per transfer.
// Each row passes the two-entry multiply lanes, which step over the ten entries in turn;
// the next queued row is taken on the last step of an unmarked row. After the marked row,
// ten consecutive entries follow; the back end takes no new row until the tenth has gone out.
// A two-row queue keeps start accepted while the back end works; busy_o flags it full.
// Reset clears the accumulators, the queue and noise_variance; the receiver cannot stall.
`default_nettype none

module mimo_gram_matrix_4x4 #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  output logic                                busy_o,
  input  wire logic signed [SAMPLE_WIDTH-1:0] h0_re_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] h0_im_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] h1_re_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] h1_im_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] h2_re_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] h2_im_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] h3_re_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] h3_im_i,
  input  wire logic                           last_row_i,
  input  wire logic                           cfg_we_i,
  input  wire logic [mgram_pkg::NV_W-1:0]     cfg_wdata_i,
  output logic                                result_valid_o,
  output logic [1:0]                          gram_row_o,
  output logic [1:0]                          gram_col_o,
  output logic signed [mgram_pkg::ACC_W-1:0]  gram_re_o,
  output logic signed [mgram_pkg::ACC_W-1:0]  gram_im_o,
  output logic                                last_entry_o
);
  import mgram_pkg::*;

  localparam int unsigned DATA_W = 8 * SAMPLE_WIDTH;

  logic [DATA_W-1:0] row_in;
  logic [DATA_W-1:0] row_q2b;
  qctl_t             qctl;
  logic              pop;

  assign row_in = {h3_im_i, h3_re_i, h2_im_i, h2_re_i,
                   h1_im_i, h1_re_i, h0_im_i, h0_re_i};

  mgram_front #(
    .DATA_W (DATA_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .row_i      (row_in),
    .last_row_i (last_row_i),
    .busy_o     (busy_o),
    .qctl_o     (qctl),
    .row_o      (row_q2b),
    .pop_i      (pop)
  );

  mgram_back #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .qctl_i         (qctl),
    .row_i          (row_q2b),
    .pop_o          (pop),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .gram_row_o     (gram_row_o),
    .gram_col_o     (gram_col_o),
    .gram_re_o      (gram_re_o),
    .gram_im_o      (gram_im_o),
    .last_entry_o   (last_entry_o)
  );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned GW     = mgram_pkg::ACC_W;
  localparam int unsigned NW     = mgram_pkg::NV_W;
  localparam int unsigned QUIET  = 40;
  localparam int unsigned NITEMS = 280;

  typedef enum logic [1:0] {
    ACT_ROW,
    ACT_SET_NV,
    ACT_SETTLE
  } pend_act_e;

  typedef struct packed {
    logic [3:0][15:0] re;
    logic [3:0][15:0] im;
    logic             last;
  } chan_row_t;

  typedef struct packed {
    pend_act_e       act;
    chan_row_t       row;
    logic [NW-1:0]   nv;
  } pend_t;

  typedef struct packed {
    logic [1:0]    row;
    logic [1:0]    col;
    logic [GW-1:0] re;
    logic [GW-1:0] im;
    logic          last;
  } gram_entry_t;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          start_i     = 1'b0;
  logic          busy_o;
  logic [15:0]   h0_re_i     = '0;
  logic [15:0]   h0_im_i     = '0;
  logic [15:0]   h1_re_i     = '0;
  logic [15:0]   h1_im_i     = '0;
  logic [15:0]   h2_re_i     = '0;
  logic [15:0]   h2_im_i     = '0;
  logic [15:0]   h3_re_i     = '0;
  logic [15:0]   h3_im_i     = '0;
  logic          last_row_i  = 1'b0;
  logic          cfg_we_i    = 1'b0;
  logic [NW-1:0] cfg_wdata_i = '0;
  logic          result_valid_o;
  logic [1:0]    gram_row_o;
  logic [1:0]    gram_col_o;
  logic [GW-1:0] gram_re_o;
  logic [GW-1:0] gram_im_o;
  logic          last_entry_o;

  mimo_gram_matrix_4x4 u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .h0_re_i        (h0_re_i),
    .h0_im_i        (h0_im_i),
    .h1_re_i        (h1_re_i),
    .h1_im_i        (h1_im_i),
    .h2_re_i        (h2_re_i),
    .h2_im_i        (h2_im_i),
    .h3_re_i        (h3_re_i),
    .h3_im_i        (h3_im_i),
    .last_row_i     (last_row_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .gram_row_o     (gram_row_o),
    .gram_col_o     (gram_col_o),
    .gram_re_o      (gram_re_o),
    .gram_im_o      (gram_im_o),
    .last_entry_o   (last_entry_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
  end

  initial begin
    #5_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  // Predictor state: lower-triangle sums indexed [row][col]
  logic [GW-1:0] sum_re [4][4];
  logic [GW-1:0] sum_im [4][4];
  logic [NW-1:0] noise_var = '0;

  pend_t         pending [$];
  gram_entry_t   gram_due [$];
  chan_row_t     cur_row = '0;
  int unsigned   gap_left = 0;
  int unsigned   quiet = 0;
  int unsigned   errors = 0;

  initial begin
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) begin
        sum_re[i][j] = '0;
        sum_im[i][j] = '0;
      end
  end

  function automatic logic [GW-1:0] widen(input logic signed [15:0] a,
                                          input logic signed [15:0] b);
    logic signed [31:0] p;
    p = a * b;
    return {{(GW-32){p[31]}}, p};
  endfunction

  // Fold one channel row into the sums; on the marked row queue the matrix
  function automatic void fold_channel_row(input chan_row_t r);
    logic signed [15:0] ar, ai, br, bi;
    gram_entry_t        g;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j <= i; j++) begin
        ar = r.re[i];
        ai = r.im[i];
        br = r.re[j];
        bi = r.im[j];
        sum_re[i][j] = sum_re[i][j] + widen(ar, br) + widen(ai, bi);
        if (i != j)
          sum_im[i][j] = sum_im[i][j] + widen(ar, bi) - widen(ai, br);
      end
    if (r.last) begin
      for (int i = 0; i < 4; i++)
        for (int j = i; j >= 0; j--) begin
          g.row  = 2'(i);
          g.col  = 2'(j);
          g.re   = (i == j) ? sum_re[i][j] + {{(GW-NW){1'b0}}, noise_var} : sum_re[i][j];
          g.im   = (i == j) ? '0 : sum_im[i][j];
          g.last = (i == 3) && (j == 0);
          gram_due.push_back(g);
          sum_re[i][j] = '0;
          sum_im[i][j] = '0;
        end
    end
  endfunction

  function automatic chan_row_t rand_row(input logic last, input int unsigned ext_pct);
    chan_row_t r;
    for (int n = 0; n < 4; n++) begin
      r.re[n] = ($urandom_range(0, 99) < ext_pct) ?
                ($urandom_range(0, 1) ? 16'h8000 : 16'h7FFF) : 16'($urandom);
      r.im[n] = ($urandom_range(0, 99) < ext_pct) ?
                ($urandom_range(0, 1) ? 16'h8000 : 16'h7FFF) : 16'($urandom);
    end
    r.last = last;
    return r;
  endfunction

  function automatic void queue_row(input chan_row_t r);
    pend_t p;
    p.act = ACT_ROW;
    p.row = r;
    p.nv  = '0;
    pending.push_back(p);
  endfunction

  function automatic void queue_step(input pend_act_e a, input logic [NW-1:0] nv);
    pend_t p;
    p.act = a;
    p.row = '0;
    p.nv  = nv;
    pending.push_back(p);
  endfunction

  // Driver: one transfer per accepted start, config and settle steps only when idle
  always @(posedge clk_i) begin : drive
    pend_t       nxt;
    logic        go;
    logic        we;
    logic        took;
    int unsigned r;
    go   = start_i;
    we   = 1'b0;
    took = 1'b0;
    if (rst_ni) begin
      if (cfg_we_i)
        noise_var = cfg_wdata_i;
      if (start_i && !busy_o) begin
        fold_channel_row(cur_row);
        took = 1'b1;
        go   = 1'b0;
        r    = $urandom_range(0, 99);
        gap_left = (r < 55) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 40);
      end
      if (took || result_valid_o)
        quiet = 0;
      else if (quiet < QUIET)
        quiet++;
      if (!go) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending.size() != 0) begin
          if (pending[0].act == ACT_ROW) begin
            nxt     = pending.pop_front();
            cur_row = nxt.row;
            go      = 1'b1;
          end else if (gram_due.size() == 0 && quiet >= QUIET) begin
            nxt = pending.pop_front();
            if (nxt.act == ACT_SET_NV) begin
              we = 1'b1;
              cfg_wdata_i <= nxt.nv;
            end
            quiet = 0;
          end
        end
      end
    end
    start_i    <= go;
    cfg_we_i   <= we;
    h0_re_i    <= cur_row.re[0];
    h0_im_i    <= cur_row.im[0];
    h1_re_i    <= cur_row.re[1];
    h1_im_i    <= cur_row.im[1];
    h2_re_i    <= cur_row.re[2];
    h2_im_i    <= cur_row.im[2];
    h3_re_i    <= cur_row.re[3];
    h3_im_i    <= cur_row.im[3];
    last_row_i <= cur_row.last;
  end

  always @(posedge clk_i) begin : watch
    gram_entry_t want;
    if (rst_ni && result_valid_o) begin
      if (gram_due.size() == 0) begin
        $error("unexpected entry (%0d,%0d)", gram_row_o, gram_col_o);
        errors++;
      end else begin
        want = gram_due.pop_front();
        if (gram_row_o !== want.row) begin
          $error("gram_row: expected %0d, got %0d", want.row, gram_row_o);
          errors++;
        end
        if (gram_col_o !== want.col) begin
          $error("gram_col: expected %0d, got %0d", want.col, gram_col_o);
          errors++;
        end
        if (gram_re_o !== want.re) begin
          $error("gram_re: expected %0d, got %0d", $signed(want.re), $signed(gram_re_o));
          errors++;
        end
        if (gram_im_o !== want.im) begin
          $error("gram_im: expected %0d, got %0d", $signed(want.im), $signed(gram_im_o));
          errors++;
        end
        if (last_entry_o !== want.last) begin
          $error("last_entry: expected %0d, got %0d", want.last, last_entry_o);
          errors++;
        end
      end
    end
  end

  initial begin : stim
    chan_row_t   row;
    int unsigned n_items;
    int unsigned mat;
    int unsigned rows;
    int unsigned pct;
    int unsigned sel;
    int unsigned n;

    // Full negative scale everywhere, largest noise variance
    queue_step(ACT_SET_NV, 32'hFFFF_FFFF);
    for (int k = 0; k < 4; k++) begin
      row.re   = {4{16'h8000}};
      row.im   = {4{16'h8000}};
      row.last = (k == 3);
      queue_row(row);
    end
    queue_step(ACT_SET_NV, '0);
    // Mixed signs of full scale between columns and rows
    for (int k = 0; k < 4; k++) begin
      for (int c = 0; c < 4; c++) begin
        row.re[c] = ((c + k) % 2 == 0) ? 16'h7FFF : 16'h8000;
        row.im[c] = ((c + k) % 2 == 0) ? 16'h8000 : 16'h7FFF;
      end
      row.last = (k == 3);
      queue_row(row);
    end
    queue_step(ACT_SETTLE, '0);
    // Single-row matrices: all zero, then smallest magnitudes
    row = '0;
    row.last = 1'b1;
    queue_row(row);
    row.re = {4{16'h0001}};
    row.im = {4{16'hFFFF}};
    queue_row(row);
    queue_step(ACT_SET_NV, 32'h4000_0000);
    // Three-row matrix
    for (int k = 0; k < 3; k++)
      queue_row(rand_row(k == 2, 10));
    n_items = 13;

    mat = 0;
    while (n_items < NITEMS) begin
      if (mat % 6 == 5) begin
        sel = $urandom_range(0, 2);
        queue_step(ACT_SET_NV, (sel == 0) ? 32'h0 : (sel == 1) ? 32'hFFFF_FFFF : $urandom);
      end
      sel = $urandom_range(0, 99);
      pct = 10;
      if (mat == 3 || sel >= 96) begin
        // long run of full-scale rows: sums wrap
        rows = $urandom_range(17, 20);
        pct  = 100;
      end else if (sel < 70) begin
        rows = 4;
      end else begin
        rows = $urandom_range(1, 8);
      end
      for (int k = 0; k < rows; k++) begin
        queue_row(rand_row(k == rows - 1, pct));
        n_items++;
      end
      if ($urandom_range(0, 7) == 0)
        queue_step(ACT_SETTLE, '0);
      mat++;
    end

    // Sample away from the driving edge so the driver's updates have settled
    while (pending.size() != 0 || start_i)
      @(negedge clk_i);
    for (n = 0; n < 4000 && gram_due.size() != 0; n++)
      @(negedge clk_i);
    repeat (QUIET) @(posedge clk_i);
    if (gram_due.size() != 0) begin
      $error("%0d entries never arrived", gram_due.size());
      errors++;
    end
    if (errors == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule
